@@ hw/rtl/fpba_pkg.sv @@
`timescale 1ns / 1ps

package fpba_pkg;

    // fixed field widths
    localparam int BLK_W    = 4;
    localparam int AMT_W    = 16;
    localparam int GCNT_W   = 16;
    localparam int WASTE_W  = 32;
    localparam int POL_W    = 2;
    localparam int BIU_W    = 5;
    localparam int RING_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam int CMD_FIFO_DEPTH = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

    localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

    // fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

    // item kinds
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic             is_load;
        logic [BLK_W-1:0] block;
        logic             in_range;
        logic [AMT_W-1:0] amount;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } eng_state_t;

endpackage

@@ hw/rtl/fit_policy_block_allocator_core.sv @@
`timescale 1ns / 1ps
// Processing: a load skips the scan; a request scans up to n blocks
//   (n = min of blocks_in_use, NUM_BLOCKS, 16; first/next fit stop at a fit).
// The back-end scan reads one block capacity per cycle and takes one command at a
//   time; the front end and command queue can keep accepting beats while it runs.
// Reset (rst_n, async low): capacities, counters and ring pointer clear to zero,
//   fit_policy to first fit, blocks_in_use to 16; no clearing pass.

module fit_policy_block_allocator_core #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] block_number, [19:4] amount, rest zero
    input  logic [0:0]  s_tuser,   // [0] action (0 load, 1 request)

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] chosen_block, [19:4] leftover,
                                   // [35:20] grant_count, [67:36] waste_total, rest zero
    output logic [0:0]  m_tuser,   // [0] granted

    // config write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index, // 0 fit_policy, 1 blocks_in_use
    input  logic [4:0]  cfg_data
);

    // front -> queue
    logic           push_valid;
    logic           push_ready;
    fpba_pkg::cmd_t push_cmd;

    // queue -> back end
    logic           pop_valid;
    logic           pop_ready;
    fpba_pkg::cmd_t pop_cmd;

    logic                            res_granted;
    logic [fpba_pkg::BLK_W-1:0]      res_chosen;
    logic [fpba_pkg::AMT_W-1:0]      res_leftover;
    logic [fpba_pkg::GCNT_W-1:0]     res_grant_count;
    logic [fpba_pkg::WASTE_W-1:0]    res_waste_total;

    // Front end: registers the beat and classifies it (load/request,
    // block range check, amount masked to SIZE_BITS).
    fpba_front #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser[0]),
        .in_block   (s_tdata[3:0]),
        .in_amount  (s_tdata[19:4]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Short command queue so the front keeps taking beats while a scan runs.
    fpba_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Back end: sequential scan over the capacities, state update and
    // result register that parts it from the output stream.
    fpba_engine #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (pop_valid),
        .cmd_ready       (pop_ready),
        .cmd             (pop_cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_granted     (res_granted),
        .out_chosen      (res_chosen),
        .out_leftover    (res_leftover),
        .out_grant_count (res_grant_count),
        .out_waste_total (res_waste_total)
    );

    // pack result beat
    assign m_tdata    = {4'b0, res_waste_total, res_grant_count, res_leftover, res_chosen};
    assign m_tuser[0] = res_granted;

endmodule

@@ hw/rtl/fpba_front.sv @@
`timescale 1ns / 1ps

module fpba_front #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_action,
    input  logic [fpba_pkg::BLK_W-1:0] in_block,
    input  logic [fpba_pkg::AMT_W-1:0] in_amount,
    output logic                      push_valid,
    input  logic                      push_ready,
    output fpba_pkg::cmd_t            push_cmd
);

    localparam logic [fpba_pkg::AMT_W-1:0] AMT_MASK =
        (SIZE_BITS >= fpba_pkg::AMT_W) ? '1 : fpba_pkg::AMT_W'((1 << SIZE_BITS) - 1);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    fpba_pkg::cmd_t hold_reg;
    fpba_pkg::cmd_t hold_next;
    fpba_pkg::cmd_t dec_cmd;

    // classify the incoming beat
    always_comb
    begin
        dec_cmd.is_load  = (in_action == fpba_pkg::ACT_LOAD);
        dec_cmd.block    = in_block;
        dec_cmd.in_range = (9'(in_block) < 9'(NUM_BLOCKS));
        dec_cmd.amount   = in_amount & AMT_MASK;
    end

    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
            hold_next       = dec_cmd;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

@@ hw/rtl/fpba_fifo.sv @@
`timescale 1ns / 1ps

module fpba_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fpba_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fpba_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = fpba_pkg::CMD_FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpba_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/fpba_engine.sv @@
`timescale 1ns / 1ps

module fpba_engine #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  fpba_pkg::cmd_t                cmd,
    input  logic                          cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpba_pkg::BIU_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_granted,
    output logic [fpba_pkg::BLK_W-1:0]    out_chosen,
    output logic [fpba_pkg::AMT_W-1:0]    out_leftover,
    output logic [fpba_pkg::GCNT_W-1:0]   out_grant_count,
    output logic [fpba_pkg::WASTE_W-1:0]  out_waste_total
);

    localparam int STORE = (NUM_BLOCKS < 16) ? NUM_BLOCKS : 16;
    localparam int IDX_W = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int BIU_W = fpba_pkg::BIU_W;

    fpba_pkg::eng_state_t state_reg;
    fpba_pkg::eng_state_t state_next;

    // block capacities, cleared by reset
    logic [SIZE_BITS-1:0] cap_reg [STORE];
    logic                 cap_we;
    logic [IDX_W-1:0]     cap_waddr;
    logic [SIZE_BITS-1:0] cap_wdata;

    logic [fpba_pkg::POL_W-1:0]   fit_policy_reg;
    logic [BIU_W-1:0]             blocks_in_use_reg;
    logic [fpba_pkg::RING_W-1:0]  ring_reg;
    logic [fpba_pkg::RING_W-1:0]  ring_next;
    logic [fpba_pkg::GCNT_W-1:0]  grants_reg;
    logic [fpba_pkg::GCNT_W-1:0]  grants_next;
    logic [fpba_pkg::WASTE_W-1:0] waste_reg;
    logic [fpba_pkg::WASTE_W-1:0] waste_next;

    fpba_pkg::cmd_t       cur_reg;
    fpba_pkg::cmd_t       cur_next;
    logic [IDX_W-1:0]     step_reg;
    logic [IDX_W-1:0]     step_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     pick_reg;
    logic [IDX_W-1:0]     pick_next;
    logic [SIZE_BITS-1:0] best_reg;
    logic [SIZE_BITS-1:0] best_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          granted_reg;
    logic                          granted_next;
    logic [fpba_pkg::BLK_W-1:0]    chosen_reg;
    logic [fpba_pkg::BLK_W-1:0]    chosen_next;
    logic [fpba_pkg::AMT_W-1:0]    leftover_reg;
    logic [fpba_pkg::AMT_W-1:0]    leftover_next;
    logic [fpba_pkg::GCNT_W-1:0]   gcnt_out_reg;
    logic [fpba_pkg::GCNT_W-1:0]   gcnt_out_next;
    logic [fpba_pkg::WASTE_W-1:0]  waste_out_reg;
    logic [fpba_pkg::WASTE_W-1:0]  waste_out_next;

    logic [BIU_W-1:0]             n_act;
    logic [IDX_W-1:0]             start_idx;
    logic [SIZE_BITS-1:0]         amt;
    logic [SIZE_BITS-1:0]         cap_rd;
    logic                         fits;
    logic                         take;
    logic                         last_step;
    logic                         scan_done;
    logic                         out_free;
    logic [SIZE_BITS-1:0]         rest;
    logic [31:0]                  rest32;
    logic [fpba_pkg::WASTE_W:0]   sum_wide;
    logic [fpba_pkg::WASTE_W-1:0] sum_sat;
    logic [fpba_pkg::GCNT_W-1:0]  grants_inc;

    // searched blocks: register value limited to the array size
    assign n_act = (blocks_in_use_reg > BIU_W'(STORE)) ? BIU_W'(STORE) : blocks_in_use_reg;

    // next fit resumes at the last chosen block if still in range
    always_comb
    begin
        start_idx = '0;
        if (fit_policy_reg == fpba_pkg::POL_NEXT && BIU_W'(ring_reg) < n_act)
        begin
            start_idx = IDX_W'(ring_reg);
        end
    end

    assign amt       = SIZE_BITS'(cur_reg.amount);
    assign cap_rd    = cap_reg[idx_reg];
    assign fits      = (cap_rd >= amt);
    assign take      = fits && (!found_reg
                     || (fit_policy_reg == fpba_pkg::POL_BEST  && cap_rd < best_reg)
                     || (fit_policy_reg == fpba_pkg::POL_WORST && cap_rd > best_reg));
    assign last_step = (BIU_W'(step_reg) == n_act - 1'b1);
    assign scan_done = last_step || (fits && (fit_policy_reg == fpba_pkg::POL_FIRST
                                           || fit_policy_reg == fpba_pkg::POL_NEXT));
    assign out_free  = !out_valid_reg || out_ready;

    assign rest       = best_reg - amt;
    assign rest32     = 32'(rest);
    assign sum_wide   = {1'b0, waste_reg} + (fpba_pkg::WASTE_W + 1)'(rest);
    assign sum_sat    = sum_wide[fpba_pkg::WASTE_W] ? '1 : sum_wide[fpba_pkg::WASTE_W-1:0];
    assign grants_inc = (grants_reg == '1) ? grants_reg : grants_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_load || n_act == '0)
                    begin
                        state_next = fpba_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = fpba_pkg::ST_SCAN;
                    end
                end
            end
            fpba_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = fpba_pkg::ST_WRITE;
                end
            end
            fpba_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = fpba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_ready      = 1'b0;
        cur_next       = cur_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        ring_next      = ring_reg;
        grants_next    = grants_reg;
        waste_next     = waste_reg;
        cap_we         = 1'b0;
        cap_waddr      = pick_reg;
        cap_wdata      = rest;
        out_valid_next = out_valid_reg && !out_ready;
        granted_next   = granted_reg;
        chosen_next    = chosen_reg;
        leftover_next  = leftover_reg;
        gcnt_out_next  = gcnt_out_reg;
        waste_out_next = waste_out_reg;
        case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next   = cmd;
                    step_next  = '0;
                    idx_next   = start_idx;
                    found_next = 1'b0;
                    pick_next  = '0;
                    best_next  = '0;
                end
            end
            fpba_pkg::ST_SCAN:
            begin
                if (take)
                begin
                    found_next = 1'b1;
                    pick_next  = idx_reg;
                    best_next  = cap_rd;
                end
                step_next = step_reg + 1'b1;
                idx_next  = (BIU_W'(idx_reg) == n_act - 1'b1) ? '0 : idx_reg + 1'b1;
            end
            fpba_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = 1'b0;
                    chosen_next    = '0;
                    leftover_next  = '0;
                    if (cur_reg.is_load)
                    begin
                        cap_we         = cur_reg.in_range;
                        cap_waddr      = cur_reg.block[IDX_W-1:0];
                        cap_wdata      = amt;
                        ring_next      = '0;
                        grants_next    = '0;
                        waste_next     = '0;
                        gcnt_out_next  = '0;
                        waste_out_next = '0;
                    end
                    else if (found_reg)
                    begin
                        cap_we         = 1'b1;
                        ring_next      = fpba_pkg::RING_W'(pick_reg);
                        grants_next    = grants_inc;
                        waste_next     = sum_sat;
                        granted_next   = 1'b1;
                        chosen_next    = fpba_pkg::BLK_W'(pick_reg);
                        leftover_next  = rest32[fpba_pkg::AMT_W-1:0];
                        gcnt_out_next  = grants_inc;
                        waste_out_next = sum_sat;
                    end
                    else
                    begin
                        gcnt_out_next  = grants_reg;
                        waste_out_next = waste_reg;
                    end
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign out_granted     = granted_reg;
    assign out_chosen      = chosen_reg;
    assign out_leftover    = leftover_reg;
    assign out_grant_count = gcnt_out_reg;
    assign out_waste_total = waste_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= fpba_pkg::ST_IDLE;
            fit_policy_reg    <= fpba_pkg::POL_FIRST;
            blocks_in_use_reg <= fpba_pkg::BIU_RESET;
            ring_reg          <= '0;
            grants_reg        <= '0;
            waste_reg         <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < STORE; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ring_reg      <= ring_next;
            grants_reg    <= grants_next;
            waste_reg     <= waste_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == fpba_pkg::REG_FIT_POLICY)
            begin
                fit_policy_reg <= cfg_data[fpba_pkg::POL_W-1:0];
            end
            if (cfg_we && cfg_index == fpba_pkg::REG_BLOCKS_IN_USE)
            begin
                blocks_in_use_reg <= cfg_data;
            end
            if (cap_we)
            begin
                cap_reg[cap_waddr] <= cap_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        step_reg      <= step_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        pick_reg      <= pick_next;
        best_reg      <= best_next;
        granted_reg   <= granted_next;
        chosen_reg    <= chosen_next;
        leftover_reg  <= leftover_next;
        gcnt_out_reg  <= gcnt_out_next;
        waste_out_reg <= waste_out_next;
    end

endmodule

@@ hw/rtl/fpba_checker.sv @@
`timescale 1ns / 1ps

module fpba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // no grant: block and leftover read zero
    a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[19:0] == 20'd0)
        else $error("refused beat carries block or leftover");

    // a grant is counted
    a_grant_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[35:20] != 16'd0)
        else $error("grant with zero grant count");

    // waste total includes this grant's leftover
    a_waste_covers: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[67:36] >= 32'(m_tdata[19:4]))
        else $error("waste total below leftover");

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ verif/fit_policy_block_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module fit_policy_block_allocator_core_tb;

    localparam int BLK_W   = fpba_pkg::BLK_W;
    localparam int AMT_W   = fpba_pkg::AMT_W;
    localparam int GCNT_W  = fpba_pkg::GCNT_W;
    localparam int WASTE_W = fpba_pkg::WASTE_W;
    localparam int POL_W   = fpba_pkg::POL_W;
    localparam int BIU_W   = fpba_pkg::BIU_W;
    localparam int RING_W  = fpba_pkg::RING_W;

    // one input beat as the sender sees it
    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] block;
        logic [AMT_W-1:0] amount;
    } alloc_beat_t;

    // one result beat, field by field
    typedef struct packed {
        logic               granted;
        logic [BLK_W-1:0]   chosen;
        logic [AMT_W-1:0]   leftover;
        logic [GCNT_W-1:0]  grants;
        logic [WASTE_W-1:0] waste;
    } alloc_outcome_t;

    localparam int LONG_HOLD = 300;   // receiver hold-off, cycles

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;        // [3:0] block_number, [19:4] amount
    logic [0:0]  s_tuser = '0;        // [0] action

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;             // [3:0] chosen_block, [19:4] leftover,
                                      // [35:20] grant_count, [67:36] waste_total
    logic [0:0]  m_tuser;             // [0] granted

    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    fit_policy_block_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator shadow: capacities, ring pointer, counters, config
    // ------------------------------------------------------------------
    logic [AMT_W-1:0]   cap_left [16];
    logic [RING_W-1:0]  ring_ptr;
    logic [GCNT_W-1:0]  grant_cnt;
    logic [WASTE_W-1:0] waste_sum;
    logic [POL_W-1:0]   fit_mode;
    logic [BIU_W-1:0]   search_width;

    alloc_beat_t    beats_to_send [$];
    alloc_outcome_t expected_outcomes [$];

    int beats_queued   = 0;
    int beats_accepted = 0;
    int mismatches     = 0;
    int loads_queued   = 0;
    int requests_queued = 0;
    int grants_seen    = 0;
    int denials_seen   = 0;

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;

    logic in_taken = 1'b0;            // input beat accepted at the last rising edge

    // hold-off request: toggled by the stimulus, noticed by the receiver
    logic        hold_off_tick = 1'b0;
    logic        hold_off_seen = 1'b0;
    int          hold_left     = 0;

    // Apply one beat to the shadow state and return what the block must report.
    function automatic alloc_outcome_t alloc_outcome(input alloc_beat_t b);
        alloc_outcome_t r;
        int n;
        int pick;
        int start;
        int k;
        logic [32:0] sum;
        r = '0;
        pick = -1;
        if (b.action == fpba_pkg::ACT_LOAD)
        begin
            // load always clears counters and ring, block index always in range here
            cap_left[b.block] = b.amount;
            grant_cnt = '0;
            waste_sum = '0;
            ring_ptr  = '0;
        end
        else
        begin
            n = (search_width > 16) ? 16 : int'(search_width);
            if (n > 0)
            begin
                if (fit_mode == fpba_pkg::POL_NEXT)
                begin
                    // ring search; stale pointer past the window restarts at 0
                    start = (int'(ring_ptr) < n) ? int'(ring_ptr) : 0;
                    for (int j = 0; j < n; j++)
                    begin
                        k = (start + j) % n;
                        if (pick < 0 && cap_left[k] >= b.amount)
                            pick = k;
                    end
                end
                else
                begin
                    // strict compares keep ties on the lowest index
                    for (int j = 0; j < n; j++)
                    begin
                        if (cap_left[j] >= b.amount)
                        begin
                            if (pick < 0)
                                pick = j;
                            else if (fit_mode == fpba_pkg::POL_BEST
                                     && cap_left[j] < cap_left[pick])
                                pick = j;
                            else if (fit_mode == fpba_pkg::POL_WORST
                                     && cap_left[j] > cap_left[pick])
                                pick = j;
                        end
                    end
                end
            end
            if (pick >= 0)
            begin
                cap_left[pick] = cap_left[pick] - b.amount;
                ring_ptr = pick[RING_W-1:0];
                if (grant_cnt != '1)
                    grant_cnt = grant_cnt + 1'b1;
                sum = {1'b0, waste_sum} + 33'(cap_left[pick]);
                waste_sum = sum[32] ? '1 : sum[31:0];
                r.granted  = 1'b1;
                r.chosen   = pick[BLK_W-1:0];
                r.leftover = cap_left[pick];
            end
        end
        r.grants = grant_cnt;
        r.waste  = waste_sum;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        alloc_beat_t    b;
        alloc_outcome_t want;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                cap_left[i] = '0;
            ring_ptr     = '0;
            grant_cnt    = '0;
            waste_sum    = '0;
            fit_mode     = fpba_pkg::POL_FIRST;
            search_width = fpba_pkg::BIU_RESET;
        end
        else
        begin
            // config only moves while the block is idle
            if (cfg_we)
            begin
                if (cfg_index == fpba_pkg::REG_FIT_POLICY)
                    fit_mode = cfg_data[POL_W-1:0];
                else
                    search_width = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                b.action = s_tuser[0];
                b.block  = s_tdata[3:0];
                b.amount = s_tdata[19:4];
                expected_outcomes = {expected_outcomes, alloc_outcome(b)};
                beats_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (m_tuser[0])
                    grants_seen++;
                else
                    denials_seen++;
                if (expected_outcomes.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("granted", 32'(want.granted), 32'(m_tuser[0]));
                    check_field("chosen_block", 32'(want.chosen), 32'(m_tdata[3:0]));
                    check_field("leftover", 32'(want.leftover), 32'(m_tdata[19:4]));
                    check_field("grant_count", 32'(want.grants), 32'(m_tdata[35:20]));
                    check_field("waste_total", want.waste, m_tdata[67:36]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: new beat at the falling edge once the last one was taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        alloc_beat_t b;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                b = beats_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, b.amount, b.block};
                s_tuser  <= b.action;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so that the
    // result path and the command queue fill and s_tready drops.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_tick != hold_off_seen)
        begin
            hold_off_seen <= hold_off_tick;
            hold_left     <= LONG_HOLD;
            m_tready      <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_load(input int blk, input logic [AMT_W-1:0] cap);
        alloc_beat_t b;
        b.action = fpba_pkg::ACT_LOAD;
        b.block  = blk[BLK_W-1:0];
        b.amount = cap;
        beats_to_send = {beats_to_send, b};
        beats_queued++;
        loads_queued++;
    endtask

    task automatic push_request(input logic [AMT_W-1:0] amt);
        alloc_beat_t b;
        b.action = fpba_pkg::ACT_REQUEST;
        b.block  = BLK_W'($urandom_range(0, 15));   // don't-care, random anyway
        b.amount = amt;
        beats_to_send = {beats_to_send, b};
        beats_queued++;
        requests_queued++;
    endtask

    // coarse steps give plenty of equal capacities -> tie-break coverage
    function automatic logic [AMT_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 60)
            return AMT_W'($urandom_range(0, 10) * 50);
        return AMT_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [AMT_W-1:0] pick_request_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 13)
            return '1;
        if (r < 63)
            return AMT_W'($urandom_range(1, 12) * 25);
        if (r < 83)
            return AMT_W'($urandom_range(1, 3000));
        return AMT_W'($urandom_range(0, 65535));
    endfunction

    // Mostly well-formed: load some blocks, then a run of requests.
    // A few stray loads mid-run clear the counters and the ring pointer.
    task automatic queue_phase(input int items, input bit preload, input int width);
        int cnt;
        int nblk;
        int nloads;
        cnt  = 0;
        nblk = (width > 16) ? 16 : width;
        if (preload)
        begin
            nloads = $urandom_range(1, nblk + 1);
            for (int i = 0; i < nloads; i++)
            begin
                if (nblk > 0 && $urandom_range(0, 99) < 85)
                    push_load($urandom_range(0, nblk - 1), pick_capacity());
                else
                    push_load($urandom_range(0, 15), pick_capacity());
                cnt++;
            end
        end
        while (cnt < items)
        begin
            if ($urandom_range(0, 99) < 8)
                push_load($urandom_range(0, 15), pick_capacity());
            else
                push_request(pick_request_size());
            cnt++;
        end
    endtask

    // every beat in, every result out (one result per beat, so then idle)
    task automatic wait_drained();
        while (beats_accepted != beats_queued || expected_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [POL_W-1:0] pol_plan [10];
        logic [BIU_W-1:0] width_plan [10];
        pol_plan   = '{fpba_pkg::POL_FIRST, fpba_pkg::POL_BEST, fpba_pkg::POL_WORST,
                       fpba_pkg::POL_NEXT, fpba_pkg::POL_NEXT, fpba_pkg::POL_BEST,
                       fpba_pkg::POL_WORST, fpba_pkg::POL_FIRST, fpba_pkg::POL_NEXT,
                       fpba_pkg::POL_BEST};
        // 0 = nothing searched, 17/31 clamp to 16, 31 also sets every data bit
        width_plan = '{5'd16, 5'd16, 5'd16, 5'd16, 5'd3,
                       5'd1, 5'd0, 5'd31, 5'd17, 5'd8};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset config (first fit, 16 blocks), all capacities zero
        push_request(16'd5);        // nothing fits an empty pool
        push_request(16'd0);        // zero size fits an empty block
        push_load(0, 16'd100);
        push_load(1, 16'd50);
        push_load(2, 16'd200);
        push_load(3, 16'd50);
        push_load(15, 16'hFFFF);
        push_load(7, 16'd0);
        push_request(16'd0);        // granted, block untouched
        push_request(16'd60);
        push_request(16'hFFFF);     // only the last block fits
        push_request(16'hFFFF);     // now nothing does
        push_request(16'd40);       // exact fit, leftover 0
        push_request(16'd300);      // denied, counters unchanged
        push_load(0, 16'hFFFF);     // clears counters
        push_request(16'd1);
        wait_drained();

        write_reg(fpba_pkg::REG_FIT_POLICY, 5'(fpba_pkg::POL_BEST));
        push_request(16'd50);       // tie between blocks 1 and 3 -> lower index
        push_request(16'd50);
        wait_drained();

        write_reg(fpba_pkg::REG_FIT_POLICY, 5'(fpba_pkg::POL_WORST));
        push_request(16'd10);
        wait_drained();

        write_reg(fpba_pkg::REG_FIT_POLICY, 5'(fpba_pkg::POL_NEXT));
        push_request(16'd10);
        push_request(16'd10);
        wait_drained();

        // random phases; idling cycles through none / sender / receiver / both
        for (int p = 0; p < 10; p++)
        begin
            write_reg(fpba_pkg::REG_FIT_POLICY, 5'(pol_plan[p]));
            write_reg(fpba_pkg::REG_BLOCKS_IN_USE, width_plan[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 70; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 70; end
                default: begin send_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            // the 3-block next-fit phase starts without loads, so the ring
            // pointer left by the 16-block phase can point past the window
            queue_phase(40, p != 4, int'(width_plan[p]));
            if (p == 0 || p == 7)
                hold_off_tick = ~hold_off_tick;
            wait_drained();
        end

        send_idle_pct  = 0;
        sink_stall_pct = 0;
        repeat (40) @(negedge clk);

        if (expected_outcomes.size() != 0)
        begin
            $error("%0d results never arrived", expected_outcomes.size());
            mismatches++;
        end

        $display("Ran %0d loads and %0d requests, all four policies, widths 0 to 31",
                 loads_queued, requests_queued);
        $display("Results seen: %0d granted, %0d denied; %0d mismatches",
                 grants_seen, denials_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_front.sv
hw/rtl/fpba_fifo.sv
hw/rtl/fpba_engine.sv
hw/rtl/fit_policy_block_allocator_core.sv
hw/rtl/fpba_checker.sv
verif/fit_policy_block_allocator_core_tb.sv
